>>> rtl/pwmca_pkg.sv
// ----------------------------------------------------------------------------
// pwmca_pkg
// shared types and constants of the pwm channel allocator
// ----------------------------------------------------------------------------
package pwmca_pkg;

   // pool sizes
   localparam int CHANNELS = 16;
   localparam int PINS     = 64;
   localparam int PIN_AW   = (PINS > 1) ? $clog2(PINS) : 1;

   // field widths
   localparam int ACTION_W = 2;
   localparam int PIN_W    = 6;
   localparam int FREQ_W   = 16;
   localparam int RES_W    = 5;
   localparam int DUTY_W   = 16;
   localparam int STATUS_W = 3;
   localparam int CHAN_W   = 4;
   localparam int CMD_W    = 2;
   localparam int PCNT_W   = 7;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PIN_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FREQUENCY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RESOLUTION = 2'd2;

   localparam logic [PCNT_W-1:0] PIN_COUNT_RESET      = 7'd40;
   localparam logic [FREQ_W-1:0] MAX_FREQUENCY_RESET  = 16'd40000;
   localparam logic [RES_W-1:0]  MAX_RESOLUTION_RESET = 5'd16;
   localparam logic [RES_W-1:0]  RES_CEILING          = 5'd16;
   localparam logic [PCNT_W-1:0] PIN_LIMIT            = PCNT_W'(PINS);

   // actions
   localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_PIN    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREQ   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_RES    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_CHANNEL = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_INIT   = 3'd5;

   // generator commands
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ATTACH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUTY   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DETACH = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PIN_W-1:0]    pin;
      logic [FREQ_W-1:0]   frequency;
      logic [RES_W-1:0]    resolution;
      logic [DUTY_W-1:0]   duty;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CHAN_W-1:0]   channel;
      logic [CMD_W-1:0]    command;
      logic [FREQ_W-1:0]   frequency_out;
      logic [RES_W-1:0]    resolution_out;
      logic [DUTY_W-1:0]   duty_out;
   } rsp_type;

endpackage

>>> rtl/pwmca_ram.sv
// ----------------------------------------------------------------------------
// pwmca_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module pwmca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pwm_channel_allocator.sv
// ----------------------------------------------------------------------------
// pwm_channel_allocator
// assigns pwm generator channels to pins and issues generator commands
// ----------------------------------------------------------------------------
// Each item (init, write or stop) is accepted in state IDLE: the accept edge
// starts a read of the pin-to-channel ram, and in the next cycle (state EXEC)
// the entry is checked, the ram and the channel busy bits are updated and the
// result is registered. The result shows on rsp_item for exactly one cycle
// with rsp_valid high, in the first cycle with busy low again; start may be
// high in that same cycle, so a new item is taken as soon as the last result
// shows, not before. The receiver cannot stall: capture rsp_item whenever
// rsp_valid is high. Every item gives one result, also on error (status
// non-zero, command none, other fields zero).
// The configuration registers are written through csr_valid/csr_ready, which
// is always ready; write them only while no item is in flight. No clearing
// pass follows reset: the pin map valid bits and channel busy bits sit in
// flops.
// ----------------------------------------------------------------------------
module pwm_channel_allocator (
   input  logic                                clock,
   input  logic                                reset,
   // item in
   input  logic                                start,
   output logic                                busy,
   input  pwmca_pkg::req_type                  req_item,
   // result out
   output logic                                rsp_valid,
   output pwmca_pkg::rsp_type                  rsp_item,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pwmca_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pwmca_pkg::CSR_DATA_W-1:0]    csr_data
);

   // sequencer states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;

   // configuration registers
   logic [pwmca_pkg::PCNT_W-1:0] pin_count_ff;
   logic [pwmca_pkg::FREQ_W-1:0] max_frequency_ff;
   logic [pwmca_pkg::RES_W-1:0]  max_resolution_ff;

   // latched item
   pwmca_pkg::req_type req_ff;

   // per-pin valid bits, per-channel busy bits
   logic [pwmca_pkg::PINS-1:0]     pin_valid_ff, pin_valid_in;
   logic [pwmca_pkg::CHANNELS-1:0] chan_busy_ff, chan_busy_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   pwmca_pkg::rsp_type rsp_ff, rsp_in;

   // pin map ram
   logic                            map_wr_en;
   logic [pwmca_pkg::PIN_AW-1:0]    map_wr_addr;
   logic [pwmca_pkg::CHAN_W-1:0]    map_wr_data;
   logic [pwmca_pkg::PIN_AW-1:0]    map_rd_addr;
   logic [pwmca_pkg::CHAN_W-1:0]    map_rd_data;

   logic                          accept;
   logic [pwmca_pkg::PIN_AW-1:0]  pin_idx;
   logic                          pin_ok;
   logic                          entry_valid;
   logic [pwmca_pkg::RES_W-1:0]   res_max;
   logic                          freq_ok;
   logic                          res_ok;
   logic                          free_found;
   logic [pwmca_pkg::CHAN_W-1:0]  free_chan;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // read the map entry of the incoming pin at the accept edge
   assign map_rd_addr = req_item.pin[pwmca_pkg::PIN_AW-1:0];

   pwmca_ram #(
      .WIDTH (pwmca_pkg::CHAN_W),
      .DEPTH (pwmca_pkg::PINS)
   ) u_pin_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // checks on the latched item
   assign pin_idx     = req_ff.pin[pwmca_pkg::PIN_AW-1:0];
   assign pin_ok      = ({1'b0, req_ff.pin} < pin_count_ff)
                     && ({1'b0, req_ff.pin} < pwmca_pkg::PIN_LIMIT);
   assign entry_valid = pin_valid_ff[pin_idx];
   assign res_max     = (max_resolution_ff > pwmca_pkg::RES_CEILING)
                        ? pwmca_pkg::RES_CEILING : max_resolution_ff;
   assign freq_ok     = (req_ff.frequency != '0)
                     && (req_ff.frequency <= max_frequency_ff);
   assign res_ok      = (req_ff.resolution != '0) && (req_ff.resolution <= res_max);

   // lowest free channel
   always_comb begin
      free_found = 1'b0;
      free_chan  = '0;
      for (int i = pwmca_pkg::CHANNELS - 1; i >= 0; i--) begin
         if (!chan_busy_ff[i]) begin
            free_found = 1'b1;
            free_chan  = pwmca_pkg::CHAN_W'(i);
         end
      end
   end

   // execute step: decide the result and the write-back
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pin_valid_in = pin_valid_ff;
      chan_busy_in = chan_busy_ff;
      map_wr_en    = 1'b0;
      map_wr_addr  = pin_idx;
      map_wr_data  = free_chan;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.status  = pwmca_pkg::ST_OK;
            rsp_in.command = pwmca_pkg::CMD_NONE;
            if (req_ff.action == pwmca_pkg::ACT_INIT || req_ff.action == pwmca_pkg::ACT_WRITE
                || req_ff.action == pwmca_pkg::ACT_STOP) begin
               if (!pin_ok) begin
                  rsp_in.status = pwmca_pkg::ST_BAD_PIN;
               end else if (req_ff.action == pwmca_pkg::ACT_INIT) begin
                  if (!freq_ok) begin
                     rsp_in.status = pwmca_pkg::ST_BAD_FREQ;
                  end else if (!res_ok) begin
                     rsp_in.status = pwmca_pkg::ST_BAD_RES;
                  end else if (entry_valid) begin
                     // re-attach the channel the pin already holds
                     rsp_in.channel        = map_rd_data;
                     rsp_in.command        = pwmca_pkg::CMD_ATTACH;
                     rsp_in.frequency_out  = req_ff.frequency;
                     rsp_in.resolution_out = req_ff.resolution;
                  end else if (free_found) begin
                     // claim the lowest free channel
                     chan_busy_in[free_chan] = 1'b1;
                     pin_valid_in[pin_idx]   = 1'b1;
                     map_wr_en               = 1'b1;
                     rsp_in.channel          = free_chan;
                     rsp_in.command          = pwmca_pkg::CMD_ATTACH;
                     rsp_in.frequency_out    = req_ff.frequency;
                     rsp_in.resolution_out   = req_ff.resolution;
                  end else begin
                     rsp_in.status = pwmca_pkg::ST_NO_CHANNEL;
                  end
               end else if (!entry_valid) begin
                  rsp_in.status = pwmca_pkg::ST_NOT_INIT;
               end else if (req_ff.action == pwmca_pkg::ACT_WRITE) begin
                  rsp_in.channel  = map_rd_data;
                  rsp_in.command  = pwmca_pkg::CMD_DUTY;
                  rsp_in.duty_out = req_ff.duty;
               end else begin
                  // stop: free the channel and drop the pin mapping
                  if (32'(map_rd_data) < pwmca_pkg::CHANNELS) begin
                     chan_busy_in[map_rd_data] = 1'b0;
                  end
                  pin_valid_in[pin_idx] = 1'b0;
                  rsp_in.channel        = map_rd_data;
                  rsp_in.command        = pwmca_pkg::CMD_DETACH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pin_valid_ff <= '0;
         chan_busy_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pin_valid_ff <= pin_valid_in;
         chan_busy_ff <= chan_busy_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_count_ff      <= pwmca_pkg::PIN_COUNT_RESET;
         max_frequency_ff  <= pwmca_pkg::MAX_FREQUENCY_RESET;
         max_resolution_ff <= pwmca_pkg::MAX_RESOLUTION_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pwmca_pkg::CSR_PIN_COUNT: begin
               pin_count_ff <= csr_data[pwmca_pkg::PCNT_W-1:0];
            end
            pwmca_pkg::CSR_MAX_FREQUENCY: begin
               max_frequency_ff <= csr_data[pwmca_pkg::FREQ_W-1:0];
            end
            pwmca_pkg::CSR_MAX_RESOLUTION: begin
               max_resolution_ff <= csr_data[pwmca_pkg::RES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

endmodule

>>> rtl/pwmca_checker.sv
// ----------------------------------------------------------------------------
// pwmca_checker
// port-level checks of the pwm channel allocator
// ----------------------------------------------------------------------------
module pwmca_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input pwmca_pkg::rsp_type rsp_item
);

   // an accepted item shows its result once its execute step is done
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result missing two cycles after accept");

   // the block is busy while the item is at work
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // results never come in consecutive cycles
   a_result_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in consecutive cycles");

   // an error result carries no command and no channel
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != pwmca_pkg::ST_OK)
      |-> (rsp_item.command == pwmca_pkg::CMD_NONE && rsp_item.channel == '0))
      else $error("error result with command or channel");

   // attach carries a non-zero frequency and a resolution within limits
   a_attach_res: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.command == pwmca_pkg::CMD_ATTACH)
      |-> (rsp_item.resolution_out != '0
           && rsp_item.resolution_out <= pwmca_pkg::RES_CEILING
           && rsp_item.frequency_out != '0))
      else $error("attach with bad frequency or resolution");

endmodule

bind pwm_channel_allocator pwmca_checker u_pwmca_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

>>> tb/sv/pwm_channel_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_channel_allocator_test
// self-checking bench for the pwm channel allocator
// ----------------------------------------------------------------------------
// Drives init, write, stop and unused-action items through the start/busy
// port and keeps a model of the channel pool and the pin map to predict every
// result. Results are taken whenever rsp_valid is high and compared field by
// field with the oldest prediction. A directed part covers the field extremes,
// the error codes, a full pool and a lowered pin limit. Register sweeps with
// mostly well-formed random traffic follow, including the extreme settings.
// ----------------------------------------------------------------------------
module pwm_channel_allocator_test;
   import pwmca_pkg::*;

   // action code the block ignores
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   req_type            req_item  = '0;
   logic               rsp_valid;
   rsp_type            rsp_item;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   pwm_channel_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // allocator model: pool occupancy, pin map and the three registers
   // ---------------------------------------------------------------------
   logic              chan_taken [CHANNELS];
   logic              map_valid  [PINS];
   logic [CHAN_W-1:0] map_chan   [PINS];
   logic [PCNT_W-1:0] cfg_pin_count = PIN_COUNT_RESET;
   logic [FREQ_W-1:0] cfg_max_freq  = MAX_FREQUENCY_RESET;
   logic [RES_W-1:0]  cfg_max_res   = MAX_RESOLUTION_RESET;

   rsp_type owed_results [$];   // predicted results not yet seen

   int errors       = 0;
   int items_sent   = 0;
   int rsp_checked  = 0;
   int settings_run = 0;
   int cycles       = 0;
   int status_seen [8];
   bit gaps_on      = 1'b1;

   initial begin
      foreach (chan_taken[c]) chan_taken[c] = 1'b0;
      foreach (map_valid[p]) begin
         map_valid[p] = 1'b0;
         map_chan[p]  = '0;
      end
      foreach (status_seen[s]) status_seen[s] = 0;
   end

   // effective pin limit: pin_count above the pin range acts as the range
   function automatic int unsigned pin_limit();
      return (cfg_pin_count > PINS) ? PINS : int'(cfg_pin_count);
   endfunction

   // effective resolution limit, capped at the generator ceiling
   function automatic int unsigned res_limit();
      return (cfg_max_res > RES_CEILING) ? int'(RES_CEILING) : int'(cfg_max_res);
   endfunction

   // works out the result of one item and updates the pool on the way
   function automatic rsp_type allocator_predict(req_type it);
      rsp_type r;
      int      free_ch;
      r = '0;
      if (it.action == ACT_UNUSED) return r;
      if (it.pin >= pin_limit()) begin
         r.status = ST_BAD_PIN;
         return r;
      end
      if (it.action == ACT_INIT) begin
         // frequency is checked before resolution
         if (it.frequency == 0 || it.frequency > cfg_max_freq) begin
            r.status = ST_BAD_FREQ;
         end else if (it.resolution == 0 || it.resolution > res_limit()) begin
            r.status = ST_BAD_RES;
         end else begin
            free_ch = -1;
            if (map_valid[it.pin]) begin
               // re-init keeps the channel already held
               free_ch = int'(map_chan[it.pin]);
            end else begin
               for (int c = CHANNELS - 1; c >= 0; c--)
                  if (!chan_taken[c]) free_ch = c;
               if (free_ch >= 0) begin
                  chan_taken[free_ch] = 1'b1;
                  map_valid[it.pin]   = 1'b1;
                  map_chan[it.pin]    = CHAN_W'(free_ch);
               end
            end
            if (free_ch < 0) begin
               r.status = ST_NO_CHANNEL;
            end else begin
               r.status         = ST_OK;
               r.channel        = CHAN_W'(free_ch);
               r.command        = CMD_ATTACH;
               r.frequency_out  = it.frequency;
               r.resolution_out = it.resolution;
            end
         end
      end else if (!map_valid[it.pin]) begin
         r.status = ST_NOT_INIT;
      end else if (it.action == ACT_WRITE) begin
         r.channel  = map_chan[it.pin];
         r.command  = CMD_DUTY;
         r.duty_out = it.duty;
      end else begin
         // stop frees the channel and clears the mapping
         r.channel = map_chan[it.pin];
         r.command = CMD_DETACH;
         chan_taken[map_chan[it.pin]] = 1'b0;
         map_valid[it.pin] = 1'b0;
         map_chan[it.pin]  = '0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // result checker: the receiver never stalls, so every strobe is taken
   // ---------------------------------------------------------------------
   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (owed_results.size() == 0) begin
               errors++;
               $display("%0t ns result with nothing predicted: expected none, actual %h",
                        $time, rsp_item);
            end else begin
               want = owed_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_item.status));
               check_field("channel", 32'(want.channel), 32'(rsp_item.channel));
               check_field("command", 32'(want.command), 32'(rsp_item.command));
               check_field("frequency_out", 32'(want.frequency_out),
                           32'(rsp_item.frequency_out));
               check_field("resolution_out", 32'(want.resolution_out),
                           32'(rsp_item.resolution_out));
               check_field("duty_out", 32'(want.duty_out), 32'(rsp_item.duty_out));
               rsp_checked++;
               status_seen[rsp_item.status]++;
            end
         end else if (rsp_valid !== 1'b0) begin
            errors++;
            $display("%0t ns rsp_valid unknown: expected 0 or 1, actual %b", $time, rsp_valid);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   function automatic req_type pack_req(logic [ACTION_W-1:0] action, int pin, int freq,
                                        int res, int duty);
      req_type it;
      it.action     = action;
      it.pin        = PIN_W'(pin);
      it.frequency  = FREQ_W'(freq);
      it.resolution = RES_W'(res);
      it.duty       = DUTY_W'(duty);
      return it;
   endfunction

   // start stays high after acceptance so back-to-back items need no toggle;
   // a random gap may drop it low first
   task automatic send_item(req_type it);
      rsp_type want;
      if (gaps_on && $urandom_range(99) < 26) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
      want = allocator_predict(it);
      owed_results.push_back(want);
      items_sent++;
   endtask

   // block goes idle: no item waiting, every result back, pipe empty
   task automatic settle();
      start <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int val);
      settle();
      repeat ($urandom_range(0, 2)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(val);
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_PIN_COUNT:      cfg_pin_count = PCNT_W'(val);
         CSR_MAX_FREQUENCY:  cfg_max_freq  = FREQ_W'(val);
         CSR_MAX_RESOLUTION: cfg_max_res   = RES_W'(val);
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(int pins, int freq, int res);
      write_csr(CSR_PIN_COUNT, pins);
      write_csr(CSR_MAX_FREQUENCY, freq);
      write_csr(CSR_MAX_RESOLUTION, res);
      settings_run++;
   endtask

   // mostly well-formed traffic on a small working set of pins so that
   // writes and stops find mapped pins and the pool fills up now and then
   function automatic req_type rand_item();
      req_type     it;
      int unsigned pick;
      int unsigned hot;
      hot  = (pin_limit() > 24) ? 24 : pin_limit();
      pick = $urandom_range(99);
      it.action = (pick < 40) ? ACT_INIT : (pick < 70) ? ACT_WRITE :
                  (pick < 95) ? ACT_STOP : ACT_UNUSED;
      pick = $urandom_range(99);
      if (pick < 60)      it.pin = PIN_W'($urandom_range(hot - 1));
      else if (pick < 85) it.pin = PIN_W'($urandom_range(pin_limit() - 1));
      else                it.pin = PIN_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 70)      it.frequency = FREQ_W'($urandom_range(cfg_max_freq, 1));
      else if (pick < 78) it.frequency = cfg_max_freq;
      else if (pick < 84) it.frequency = '0;
      else                it.frequency = FREQ_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 75)      it.resolution = RES_W'($urandom_range(res_limit(), 1));
      else if (pick < 83) it.resolution = RES_W'(res_limit());
      else if (pick < 88) it.resolution = '0;
      else                it.resolution = RES_W'($urandom);
      it.duty = DUTY_W'($urandom);
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // field extremes and every status but a full pool at the reset settings
   task automatic test_directed();
      send_item(pack_req(ACT_UNUSED, 63, 16'hFFFF, 31, 16'hFFFF));  // ignored action
      send_item(pack_req(ACT_INIT, 40, 1000, 8, 0));       // first pin past the limit
      send_item(pack_req(ACT_INIT, 63, 1000, 8, 0));
      send_item(pack_req(ACT_WRITE, 5, 0, 0, 16'h1234));   // never initialized
      send_item(pack_req(ACT_STOP, 5, 0, 0, 0));
      send_item(pack_req(ACT_INIT, 0, 0, 8, 0));           // zero frequency
      send_item(pack_req(ACT_INIT, 0, 40001, 8, 0));       // one above max
      send_item(pack_req(ACT_INIT, 0, 65535, 31, 0));      // frequency checked first
      send_item(pack_req(ACT_INIT, 0, 40000, 0, 0));       // zero resolution
      send_item(pack_req(ACT_INIT, 0, 1, 17, 0));          // one above ceiling
      send_item(pack_req(ACT_INIT, 0, 40000, 16, 0));      // both at max
      send_item(pack_req(ACT_INIT, 39, 1, 1, 0));          // both at min, last pin
      send_item(pack_req(ACT_INIT, 0, 1234, 8, 0));        // re-init keeps channel
      send_item(pack_req(ACT_WRITE, 0, 0, 0, 16'h0000));
      send_item(pack_req(ACT_WRITE, 39, 0, 0, 16'hFFFF));
      send_item(pack_req(ACT_STOP, 0, 0, 0, 0));
      send_item(pack_req(ACT_STOP, 0, 0, 0, 0));           // already stopped
      send_item(pack_req(ACT_INIT, 20, 500, 12, 0));       // lowest free channel again
      send_item(pack_req(ACT_WRITE, 20, 16'hFFFF, 31, 16'hA5A5));
      send_item(pack_req(ACT_UNUSED, 0, 0, 0, 0));
      settle();
   endtask

   // fill the pool, overflow it, free one channel and reuse it
   task automatic test_pool_full();
      for (int p = 0; p < 16; p++)
         send_item(pack_req(ACT_INIT, p, 100 + p, 1 + p % 16, 0));
      send_item(pack_req(ACT_STOP, 5, 0, 0, 0));
      send_item(pack_req(ACT_INIT, 15, 7, 3, 0));
      send_item(pack_req(ACT_STOP, 15, 0, 0, 0));
      settle();
   endtask

   // a mapped pin above a lowered limit is locked out until it is raised
   task automatic test_pin_limit();
      set_config(PINS, int'(MAX_FREQUENCY_RESET), int'(MAX_RESOLUTION_RESET));
      send_item(pack_req(ACT_INIT, 50, 2000, 10, 0));
      write_csr(CSR_PIN_COUNT, 10);
      send_item(pack_req(ACT_WRITE, 50, 0, 0, 16'h00FF));
      send_item(pack_req(ACT_STOP, 50, 0, 0, 0));
      write_csr(CSR_PIN_COUNT, PINS);
      send_item(pack_req(ACT_WRITE, 50, 0, 0, 16'h00FF));
      send_item(pack_req(ACT_STOP, 50, 0, 0, 0));
      settle();
   endtask

   task automatic test_random_phase(int pins, int freq, int res, int count);
      set_config(pins, freq, res);
      repeat (count) send_item(rand_item());
      settle();
   endtask

   // register sweep including both ends of every register
   task automatic test_config_sweep();
      test_random_phase(int'(PIN_COUNT_RESET), int'(MAX_FREQUENCY_RESET),
                        int'(MAX_RESOLUTION_RESET), 210);
      gaps_on = 1'b0;   // back-to-back stretch
      test_random_phase(PINS, 65535, 16, 210);
      gaps_on = 1'b1;
      test_random_phase(1, 1, 1, 150);
      test_random_phase(127, 65535, 31, 210);   // both above their ceilings
      test_random_phase(8, 1000, 8, 210);
      test_random_phase(17, 300, 4, 210);
      repeat (2)
         test_random_phase($urandom_range(64, 1), $urandom_range(65535, 1),
                           $urandom_range(16, 1), 150);
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_pool_full();
      test_pin_limit();
      test_config_sweep();

      settle();
      repeat (10) @(posedge clock);   // any stray strobe shows up here
      if (owed_results.size() != 0) begin
         errors++;
         $display("%0t ns results missing: expected 0 outstanding, actual %0d",
                  $time, owed_results.size());
      end

      $display("ran %0d items over %0d register settings, %0d results compared",
               items_sent, settings_run, rsp_checked);
      $write("status mix: ok %0d, bad pin %0d, bad freq %0d, ",
             status_seen[ST_OK], status_seen[ST_BAD_PIN], status_seen[ST_BAD_FREQ]);
      $display("bad res %0d, pool full %0d, unmapped %0d",
               status_seen[ST_BAD_RES], status_seen[ST_NO_CHANNEL], status_seen[ST_NOT_INIT]);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/pwmca_pkg.sv
rtl/pwmca_ram.sv
rtl/pwm_channel_allocator.sv
rtl/pwmca_checker.sv
tb/sv/pwm_channel_allocator_test.sv
